/* sv/bzr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_pkg
// Shared types and constants of the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bzr_pkg;

  // curve parameter t is Q1.16, one is 2^16
  localparam int Q_BITS = 16;
  localparam int T_W    = Q_BITS + 1;
  localparam logic [T_W-1:0] Q_ONE = T_W'(1) << Q_BITS;

  // product of two powers, at most 2^32
  localparam int W_W = 2 * Q_BITS + 1;

  // register index map
  localparam int REG_NUM_POINTS = 0;
  localparam int NP_CFG_W       = 5;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // bits needed by the widest binomial coefficient of a row for n points
  function automatic int binom_width(input int n);
    longint row [0:63];
    longint top;
    int     r;
    int     i;
    for (i = 0; i < 64; i++) begin
      row[i] = 0;
    end
    row[0] = 1;
    for (r = 1; r < n; r++) begin
      for (i = r; i > 0; i--) begin
        row[i] = row[i] + row[i-1];
      end
    end
    top = 0;
    for (i = 0; i < 64; i++) begin
      if (row[i] > top) begin
        top = row[i];
      end
    end
    return $clog2(top + 1);
  endfunction

endpackage
`default_nettype wire

/* sv/bzr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bzr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/bezier_curve_point_evaluator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Bernstein-form Bezier evaluation over a stored set of control points.
// ----------------------------------------------------------------------------
// A load beat (command 0) writes one control point into the point RAM in the
// cycle it is taken and gives no result; loads are taken one per cycle while
// in_stall is low. An evaluate beat (command 1) gives one curve point, n being
// num_points: the (1-t) power recurrence fills the power RAM with n powers
// through one 17x17 multiplier, then n terms issue through a five-stage term
// pipeline that reads the point and power RAMs, and a drain and round step
// follow. Results are rounded to nearest and saturated. A waiting result
// blocks nothing until the next evaluation is ready to hand over its own
// result. After reset, and after each write of num_points, the binomial row
// is rebuilt by the Pascal rule while in_stall is high.
// num_points is clamped to 2..MAX_POINTS on write.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [3:0]                    in_point_index,
  input  wire logic signed [COORD_BITS-1:0]  in_point_x,
  input  wire logic signed [COORD_BITS-1:0]  in_point_y,
  input  wire logic [bzr_pkg::T_W-1:0]       in_curve_param,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_BITS-1:0]       out_curve_x,
  output logic signed [COORD_BITS-1:0]       out_curve_y,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  import bzr_pkg::*;

  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int NP_W     = $clog2(MAX_POINTS + 1);
  localparam int CW       = binom_width(MAX_POINTS);
  localparam int ACC_W    = COORD_BITS + 33;
  localparam int PI_W     = (IDX_W > 4) ? IDX_W : 4;
  localparam int NP_RESET = (MAX_POINTS < 4) ? MAX_POINTS : 4;
  localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPOW,
    ST_TERM,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // control
  state_t                  state_r;
  logic [IDX_W-1:0]        cnt_r;
  logic [3:0]              pv_r;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   out_x_r;
  logic [COORD_BITS-1:0]   out_y_r;

  // configuration and binomial row
  logic [NP_W-1:0]         n_r;
  logic [IDX_W-1:0]        rb_cnt_r;
  logic [CW-1:0]           row_r [MAX_POINTS];
  logic                    rebuild_busy;
  logic                    cfg_hit;
  logic [5:0]              cfg_n6;
  logic [NP_W-1:0]         cfg_n;
  logic [NP_W-1:0]         cfg_n_m1;

  // handshake decode
  logic                    in_acc;
  logic                    load_go;
  logic                    eval_go;
  logic [PI_W-1:0]         idx_ext;
  logic                    pt_we;
  logic [NP_W-1:0]         n_m1;
  logic [IDX_W-1:0]        last_idx;
  logic                    cnt_last;
  logic [NP_W-1:0]         pr_full;
  logic [IDX_W-1:0]        pow_raddr;

  // datapath
  logic [T_W-1:0]          t_sat;
  logic [T_W-1:0]          t_r;
  logic [T_W-1:0]          u_r;
  logic [T_W-1:0]          pw_r;
  logic [2*T_W-1:0]        pw_prod;
  logic [T_W-1:0]          pw_nxt;
  logic [T_W-1:0]          tp_r;
  logic [2*T_W-1:0]        tp_prod;
  logic [T_W-1:0]          tp_nxt;
  logic [T_W-1:0]          tp_s1;
  logic [CW-1:0]           coef_s1;
  logic [T_W-1:0]          pow_rdata;
  logic [2*COORD_BITS-1:0] pt_rdata;
  logic [2*T_W-1:0]        ut_full;
  logic [W_W-1:0]          ut_s2;
  logic [CW-1:0]           coef_s2;
  logic signed [COORD_BITS-1:0] px_s2;
  logic signed [COORD_BITS-1:0] py_s2;
  logic [W_W+CW-1:0]       w_full;
  logic [W_W-1:0]          w_s3;
  logic signed [COORD_BITS-1:0] px_s3;
  logic signed [COORD_BITS-1:0] py_s3;
  logic signed [COORD_BITS+W_W:0] tx_full;
  logic signed [COORD_BITS+W_W:0] ty_full;
  logic signed [ACC_W-1:0] tx_s4;
  logic signed [ACC_W-1:0] ty_s4;
  logic signed [ACC_W-1:0] acc_x_r;
  logic signed [ACC_W-1:0] acc_y_r;
  logic [ACC_W-1:0]        rnd_x;
  logic [ACC_W-1:0]        rnd_y;
  logic [COORD_BITS-1:0]   sat_x;
  logic [COORD_BITS-1:0]   sat_y;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS:0] v);
    logic [COORD_BITS-1:0] res;
    if (v[COORD_BITS] != v[COORD_BITS-1]) begin
      res = v[COORD_BITS] ? C_MIN : C_MAX;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // handshake and address decode
  // --------------------------------------------------------------------------
  assign rebuild_busy = (rb_cnt_r != '0);
  assign in_stall     = (state_r != ST_IDLE) || rebuild_busy;
  assign in_acc       = in_valid && !in_stall;
  assign load_go      = in_acc && (in_command == CMD_LOAD);
  assign eval_go      = in_acc && (in_command == CMD_EVAL);

  assign idx_ext   = PI_W'(in_point_index);
  assign pt_we     = load_go && (32'(in_point_index) < MAX_POINTS);

  assign n_m1      = n_r - NP_W'(1);
  assign last_idx  = n_m1[IDX_W-1:0];
  assign cnt_last  = (cnt_r == last_idx);
  // powers of (1-t) are read in reverse order
  assign pr_full   = n_m1 - NP_W'(cnt_r);
  assign pow_raddr = pr_full[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_hit = psel && penable && pwrite && (paddr[2] == 1'(REG_NUM_POINTS));
  assign prdata  = (paddr[2] == 1'(REG_NUM_POINTS)) ? 32'(n_r) : '0;

  always_comb begin
    cfg_n6 = 6'(pwdata[NP_CFG_W-1:0]);
    if (cfg_n6 < 6'd2) begin
      cfg_n6 = 6'd2;
    end else if (32'(cfg_n6) > MAX_POINTS) begin
      cfg_n6 = 6'(MAX_POINTS);
    end
  end

  assign cfg_n    = cfg_n6[NP_W-1:0];
  assign cfg_n_m1 = cfg_n - NP_W'(1);

  // pascal step on all lanes at once, one step a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= NP_W'(NP_RESET);
      rb_cnt_r <= IDX_W'(NP_RESET - 1);
      for (int i = 0; i < MAX_POINTS; i++) begin
        row_r[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else if (cfg_hit) begin
      n_r      <= cfg_n;
      rb_cnt_r <= cfg_n_m1[IDX_W-1:0];
      for (int i = 0; i < MAX_POINTS; i++) begin
        row_r[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else if (rebuild_busy) begin
      rb_cnt_r <= rb_cnt_r - IDX_W'(1);
      for (int i = 1; i < MAX_POINTS; i++) begin
        row_r[i] <= row_r[i] + row_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // memories: x/y point store and (1-t) power table
  // loads land only while idle, so reads of an evaluation never overlap them
  // --------------------------------------------------------------------------
  bzr_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (idx_ext[IDX_W-1:0]),
    .wdata ({in_point_x, in_point_y}),
    .raddr (cnt_r),
    .rdata (pt_rdata)
  );

  bzr_ram #(
    .WIDTH (T_W),
    .DEPTH (MAX_POINTS)
  ) u_pow_ram (
    .clk   (clk),
    .we    (state_r == ST_UPOW),
    .waddr (cnt_r),
    .wdata (pw_r),
    .raddr (pow_raddr),
    .rdata (pow_rdata)
  );

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  assign t_sat   = (in_curve_param > Q_ONE) ? Q_ONE : in_curve_param;
  assign pw_prod = pw_r * u_r;
  assign pw_nxt  = pw_prod[Q_BITS+T_W-1:Q_BITS];
  assign tp_prod = tp_r * t_r;
  assign tp_nxt  = tp_prod[Q_BITS+T_W-1:Q_BITS];

  assign ut_full = pow_rdata * tp_s1;
  // every weight is at most 2^32, upper product bits are zero
  assign w_full  = ut_s2 * coef_s2;
  assign tx_full = $signed({1'b0, w_s3}) * px_s3;
  assign ty_full = $signed({1'b0, w_s3}) * py_s3;

  always_ff @(posedge clk) begin
    if (eval_go) begin
      t_r     <= t_sat;
      u_r     <= Q_ONE - t_sat;
      pw_r    <= Q_ONE;
      tp_r    <= Q_ONE;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      if (state_r == ST_UPOW) begin
        pw_r <= pw_nxt;
      end
      if (state_r == ST_TERM) begin
        tp_r <= tp_nxt;
      end
      if (pv_r[3]) begin
        acc_x_r <= acc_x_r + tx_s4;
        acc_y_r <= acc_y_r + ty_s4;
      end
    end
    // term pipeline, point and power data arrive in the cycle after issue
    tp_s1   <= tp_r;
    coef_s1 <= row_r[cnt_r];
    ut_s2   <= ut_full[W_W-1:0];
    coef_s2 <= coef_s1;
    px_s2   <= pt_rdata[2*COORD_BITS-1:COORD_BITS];
    py_s2   <= pt_rdata[COORD_BITS-1:0];
    w_s3    <= w_full[W_W-1:0];
    px_s3   <= px_s2;
    py_s3   <= py_s2;
    tx_s4   <= tx_full[ACC_W-1:0];
    ty_s4   <= ty_full[ACC_W-1:0];
  end

  // round to nearest at 2^32 scale, then saturate
  assign rnd_x = acc_x_r + ACC_W'(64'h8000_0000);
  assign rnd_y = acc_y_r + ACC_W'(64'h8000_0000);
  assign sat_x = sat_coord(rnd_x[ACC_W-1:32]);
  assign sat_y = sat_coord(rnd_y[ACC_W-1:32]);

  // --------------------------------------------------------------------------
  // sequencer and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r <= {pv_r[2:0], state_r == ST_TERM};
      // the done step handles its own beat hand-over
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (eval_go) begin
            state_r <= ST_UPOW;
            cnt_r   <= '0;
          end
        end
        ST_UPOW: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= ST_TERM;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        ST_TERM: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (pv_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the previous beat to leave the result register
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sat_x;
            out_y_r     <= sat_y;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> pv_r == '0)
    else $error("term pipeline not empty at result");

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    eval_go |=> (state_r == ST_UPOW && cnt_r == '0))
    else $error("evaluation did not start at power step zero");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done step");

  a_np_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(n_r) >= 2) && (32'(n_r) <= MAX_POINTS))
    else $error("point count out of range");

endmodule
`default_nettype wire
